>>> hdl/fpbs_pkg.sv
// ----------------------------------------------------------------------------
// fpbs_pkg
// Shared types, constants and the fraction table for the fixed-point
// bit-by-bit square root pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package fpbs_pkg;

    // field widths
    localparam int VALUE_W    = 10;
    localparam int ROOT_W     = 8;
    localparam int WHOLE_W    = 4;
    localparam int HUND_W     = 7;
    localparam int RAD_W      = 16;
    localparam int SPLIT_BITS = 4;

    // largest value in range
    localparam logic [VALUE_W-1:0] VALUE_MAX = VALUE_W'(255);

    // default radicand shift
    localparam int FRAC_BITS_DEF = 8;

    // one pipeline slot of the root search
    typedef struct packed {
        logic [RAD_W-1:0]  radicand;
        logic [ROOT_W-1:0] root;
        logic              range_error;
    } fpbs_stage_t;

    // low root nibble in hundredths: n * 100 / 15, truncated
    function automatic logic [HUND_W-1:0] frac_hundredths(input logic [SPLIT_BITS-1:0] n);
        logic [HUND_W-1:0] r;
        case (n)
            4'd0:    r = 7'd0;
            4'd1:    r = 7'd6;
            4'd2:    r = 7'd13;
            4'd3:    r = 7'd20;
            4'd4:    r = 7'd26;
            4'd5:    r = 7'd33;
            4'd6:    r = 7'd40;
            4'd7:    r = 7'd46;
            4'd8:    r = 7'd53;
            4'd9:    r = 7'd60;
            4'd10:   r = 7'd66;
            4'd11:   r = 7'd73;
            4'd12:   r = 7'd80;
            4'd13:   r = 7'd86;
            4'd14:   r = 7'd93;
            4'd15:   r = 7'd100;
            default: r = 7'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/fpbs_step.sv
// ----------------------------------------------------------------------------
// fpbs_step
// One pipeline stage of the square root search: tries one root bit and keeps
// it when the trial square does not exceed the radicand.
// ----------------------------------------------------------------------------
`default_nettype none

module fpbs_step #(
    parameter int BIT_POS = 7
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         in_valid,
    output logic                        in_ready,
    input  wire fpbs_pkg::fpbs_stage_t  in_data,
    output logic                        out_valid,
    input  wire                         out_ready,
    output fpbs_pkg::fpbs_stage_t       out_data
);
    import fpbs_pkg::*;

    localparam logic [ROOT_W-1:0] TRIAL_BIT = ROOT_W'(1) << BIT_POS;
    localparam logic [ROOT_W-1:0] LOW_MASK  = TRIAL_BIT - ROOT_W'(1);

    logic              valid_reg;
    logic              valid_next;
    fpbs_stage_t       data_reg;
    fpbs_stage_t       data_next;
    logic [ROOT_W-1:0] trial;
    logic [RAD_W-1:0]  trial_sq;

    // stage takes a transfer when empty or when its content moves on
    assign in_ready = !valid_reg || out_ready;

    // trial bit test
    always_comb begin
        trial     = in_data.root | TRIAL_BIT;
        trial_sq  = RAD_W'(trial) * RAD_W'(trial);
        data_next = in_data;
        if (trial_sq <= in_data.radicand) begin
            data_next.root = trial;
        end
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    // control register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // root never squares past the radicand
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (RAD_W'(data_reg.root) * RAD_W'(data_reg.root)) <= data_reg.radicand)
        else $error("fpbs_step: root square exceeds radicand");

    // bits below the tested one are still clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (data_reg.root & LOW_MASK) == '0)
        else $error("fpbs_step: untested root bits set");

    // out of range items carry a zero root
    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && data_reg.range_error) |-> data_reg.root == '0)
        else $error("fpbs_step: error item has nonzero root");

endmodule

`default_nettype wire

>>> hdl/fixed_point_bitwise_sqrt.sv
// Pipeline: one stage per root bit (8 stages), then the output register
// that forms the integer and fraction.
// Throughput: one item per cycle while m_ready is high; each stage holds one
// item and moves it on when the next stage is free, so a stall fills bubbles and drops nothing.
// Reset: aresetn synchronous active low clears all stage valid bits.
// ----------------------------------------------------------------------------
// fixed_point_bitwise_sqrt
// Pipelined floor square root of value shifted left by FRAC_BITS, giving a
// Q4.4 root with its integer part and fraction in hundredths.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_bitwise_sqrt #(
    parameter int FRAC_BITS = fpbs_pkg::FRAC_BITS_DEF
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_valid,
    output logic                            s_ready,
    input  wire [fpbs_pkg::VALUE_W-1:0]     s_value,
    output logic                            m_valid,
    input  wire                             m_ready,
    output logic [fpbs_pkg::ROOT_W-1:0]     m_root_fixed,
    output logic [fpbs_pkg::WHOLE_W-1:0]    m_whole_part,
    output logic [fpbs_pkg::HUND_W-1:0]     m_fraction_hundredths,
    output logic                            m_range_error
);
    import fpbs_pkg::*;

    localparam int NSTAGE = ROOT_W;

    logic        stg_valid [0:NSTAGE];
    logic        stg_ready [0:NSTAGE];
    fpbs_stage_t stg_data  [0:NSTAGE];

    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_ready;
    logic [ROOT_W-1:0]   root_reg;
    logic [WHOLE_W-1:0]  whole_reg;
    logic [HUND_W-1:0]   hund_reg;
    logic                err_reg;
    logic                err_in;

    // input slot: out of range values get a zero radicand
    assign err_in = s_value > VALUE_MAX;
    always_comb begin
        stg_data[0].range_error = err_in;
        stg_data[0].root        = '0;
        stg_data[0].radicand    = err_in ? '0
                                         : (RAD_W'(s_value[ROOT_W-1:0]) << FRAC_BITS);
    end
    assign stg_valid[0] = s_valid;
    assign s_ready      = stg_ready[0];

    // one stage per root bit, top bit first
    for (genvar i = 0; i < NSTAGE; i++) begin : g_step
        fpbs_step #(
            .BIT_POS (NSTAGE - 1 - i)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[i]),
            .in_ready  (stg_ready[i]),
            .in_data   (stg_data[i]),
            .out_valid (stg_valid[i+1]),
            .out_ready (stg_ready[i+1]),
            .out_data  (stg_data[i+1])
        );
    end

    // output register
    assign out_ready          = !out_valid_reg || m_ready;
    assign stg_ready[NSTAGE]  = out_ready;
    assign out_valid_next     = out_ready ? stg_valid[NSTAGE] : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // split root into integer part and hundredths
    always_ff @(posedge aclk) begin
        if (out_ready && stg_valid[NSTAGE]) begin
            root_reg  <= stg_data[NSTAGE].root;
            whole_reg <= stg_data[NSTAGE].root[ROOT_W-1:SPLIT_BITS];
            hund_reg  <= frac_hundredths(stg_data[NSTAGE].root[SPLIT_BITS-1:0]);
            err_reg   <= stg_data[NSTAGE].range_error;
        end
    end

    assign m_valid               = out_valid_reg;
    assign m_root_fixed          = root_reg;
    assign m_whole_part          = whole_reg;
    assign m_fraction_hundredths = hund_reg;
    assign m_range_error         = err_reg;

    // integer part tracks the root
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> whole_reg == root_reg[ROOT_W-1:SPLIT_BITS])
        else $error("fixed_point_bitwise_sqrt: whole part mismatch");

    // error results are all zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && err_reg) |-> (root_reg == '0 && hund_reg == '0 && whole_reg == '0))
        else $error("fixed_point_bitwise_sqrt: error result not cleared");

    // fraction stays within 0..100
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> hund_reg <= HUND_W'(100))
        else $error("fixed_point_bitwise_sqrt: fraction out of range");

endmodule

`default_nettype wire
